>>> rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, types and helpers of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int NORMAL_WIDTH = 16;
   localparam int EDGE_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * EDGE_WIDTH;
   localparam int CROSS_WIDTH  = PROD_WIDTH + 1;
   localparam int MAG_WIDTH    = CROSS_WIDTH;
   localparam int SHIFT_WIDTH  = 7;
   localparam int M_WIDTH      = 30;
   localparam int SQ_WIDTH     = 2 * M_WIDTH + 2;
   localparam int LEN_WIDTH    = M_WIDTH + 1;
   localparam int NUM_WIDTH    = M_WIDTH + NORMAL_WIDTH + 1;
   localparam int SQRT_STEPS   = LEN_WIDTH;
   localparam int DIV_STEPS    = NUM_WIDTH;
   localparam int REQ_BYTES    = (9 * COORD_WIDTH + 7) / 8;
   localparam int RSP_BYTES    = (3 * NORMAL_WIDTH + 7) / 8;
   localparam logic [NORMAL_WIDTH-1:0] QMAX = {1'b0, {(NORMAL_WIDTH-1){1'b1}}};
   localparam logic [31:0] MIN_LENGTH_RESET = 32'd1678;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [EDGE_WIDTH-1:0]  edge_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;
   typedef logic [MAG_WIDTH-1:0]          mag_type;
   typedef logic [M_WIDTH-1:0]            mant_type;

   // Bit length of a magnitude.
   function automatic logic [SHIFT_WIDTH-1:0] bit_length(input mag_type v);
      logic [SHIFT_WIDTH-1:0] n;
      n = '0;
      for (int i = 0; i < MAG_WIDTH; i++) begin
         if (v[i]) begin
            n = SHIFT_WIDTH'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, the six products and the exact cross product, three stages.
// ----------------------------------------------------------------------------
module tfn_cross (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  tfn_pkg::coord_type      p [9],
   output logic                    out_valid,
   output tfn_pkg::cross_type      c [3]
);
   import tfn_pkg::*;

   logic                          v1_ff, v2_ff, v3_ff;
   edge_type                      e1_ff [3], e2_ff [3];
   logic signed [PROD_WIDTH-1:0]  pr_ff [6];
   cross_type                     c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EDGE_WIDTH'(p[3+i]) - EDGE_WIDTH'(p[i]);
            e2_ff[i] <= EDGE_WIDTH'(p[6+i]) - EDGE_WIDTH'(p[i]);
         end
         pr_ff[0] <= e1_ff[1] * e2_ff[2];
         pr_ff[1] <= e1_ff[2] * e2_ff[1];
         pr_ff[2] <= e1_ff[2] * e2_ff[0];
         pr_ff[3] <= e1_ff[0] * e2_ff[2];
         pr_ff[4] <= e1_ff[0] * e2_ff[1];
         pr_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= CROSS_WIDTH'(pr_ff[2*i]) - CROSS_WIDTH'(pr_ff[2*i+1]);
         end
      end
   end

   assign out_valid = v3_ff;
   assign c = c_ff;

endmodule

>>> rtl/tfn_scale.sv
// ----------------------------------------------------------------------------
// tfn_scale
// Magnitudes, threshold test and block shift to 30-bit mantissas.
// ----------------------------------------------------------------------------
module tfn_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  tfn_pkg::cross_type   c [3],
   input  logic [31:0]          min_length,
   output logic                 out_valid,
   output tfn_pkg::mant_type    m [3],
   output logic [2:0]           neg,
   output logic                 degenerate
);
   import tfn_pkg::*;

   logic                   v1_ff, v2_ff, v3_ff;
   mag_type                a_ff [3];
   logic [2:0]             n1_ff, n2_ff, n3_ff;
   logic [SHIFT_WIDTH-1:0] b_ff;
   logic                   big_ff, big2_ff;
   logic [66:0]            sum_ff;
   logic [63:0]            thr_ff;
   logic                   dg_ff;
   mant_type               m_ff [3];
   mant_type               m3_ff [3];
   logic                   big;
   logic [SHIFT_WIDTH-1:0] bl;
   logic [63:0]            sq [3];

   always_comb begin
      big = 1'b0;
      bl  = '0;
      for (int i = 0; i < 3; i++) begin
         if (c[i] < 0) begin
            if (-c[i] > 32'hFFFF_FFFF) big = 1'b1;
            if (bit_length(mag_type'(-c[i])) > bl) bl = bit_length(mag_type'(-c[i]));
         end else begin
            if (c[i] > 32'hFFFF_FFFF) big = 1'b1;
            if (bit_length(mag_type'(c[i])) > bl) bl = bit_length(mag_type'(c[i]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq[i] = a_ff[i][31:0] * a_ff[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i]  <= c[i] < 0 ? mag_type'(-c[i]) : mag_type'(c[i]);
            n1_ff[i] <= c[i] < 0;
         end
         b_ff   <= bl;
         big_ff <= big;
         thr_ff <= min_length * min_length;
         sum_ff <= 67'(sq[0]) + 67'(sq[1]) + 67'(sq[2]);
         n2_ff <= n1_ff;
         for (int i = 0; i < 3; i++) begin
            if (b_ff > SHIFT_WIDTH'(M_WIDTH)) begin
               m_ff[i] <= M_WIDTH'(a_ff[i] >> (b_ff - SHIFT_WIDTH'(M_WIDTH)));
            end else begin
               m_ff[i] <= M_WIDTH'(a_ff[i] << (SHIFT_WIDTH'(M_WIDTH) - b_ff));
            end
         end
         big2_ff <= big_ff;
         dg_ff   <= !big2_ff && !(sum_ff > 67'(thr_ff));
         n3_ff   <= n2_ff;
         m3_ff   <= m_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign neg        = n3_ff;
   assign m          = m3_ff;
   assign degenerate = dg_ff;

endmodule

>>> rtl/tfn_norm.sv
// ----------------------------------------------------------------------------
// tfn_norm
// Pipelined square root of the sum of squared mantissas and three pipelined dividers.
// ----------------------------------------------------------------------------
module tfn_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  tfn_pkg::mant_type   m [3],
   input  logic [2:0]          neg,
   input  logic                degenerate,
   output logic                out_valid,
   output logic [tfn_pkg::NORMAL_WIDTH-1:0] n [3],
   output logic                out_degenerate
);
   import tfn_pkg::*;

   localparam int SL = SQRT_STEPS;
   localparam int DL = DIV_STEPS;
   localparam int TOT = SL + DL + 2;

   logic               vld_ff [TOT+1];
   logic [2:0]         neg_ff [TOT+1];
   logic               dg_ff  [TOT+1];

   logic [2*M_WIDTH-1:0] sq [3];
   mant_type             ms_ff [SL+1][3];
   logic [SQ_WIDTH-1:0]  rx_ff [SL+1];
   logic [SQ_WIDTH-1:0]  rr_ff [SL+1];

   logic [LEN_WIDTH-1:0] len_ff [DL+1];
   logic [NUM_WIDTH-1:0] nm_ff  [DL+1][3];
   logic [NUM_WIDTH:0]   rm_ff  [DL+1][3];
   logic [NUM_WIDTH-1:0] qt_ff  [DL+1][3];
   logic [NORMAL_WIDTH-1:0] o_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq[i] = m[i] * m[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= TOT; k++) vld_ff[k] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= TOT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      logic [SQ_WIDTH-1:0] bt, x, r;
      logic [NUM_WIDTH:0] rem, d2;
      if (enable) begin
         neg_ff[0] <= neg;
         dg_ff[0]  <= degenerate;
         for (int k = 1; k <= TOT; k++) begin
            neg_ff[k] <= neg_ff[k-1];
            dg_ff[k]  <= dg_ff[k-1];
         end
         for (int i = 0; i < 3; i++) ms_ff[0][i] <= m[i];
         rx_ff[0] <= SQ_WIDTH'(sq[0]) + SQ_WIDTH'(sq[1]) + SQ_WIDTH'(sq[2]);
         rr_ff[0] <= '0;
         for (int k = 0; k < SL; k++) begin
            bt = SQ_WIDTH'(1) << (2 * (SL - 1 - k));
            x  = rx_ff[k];
            r  = rr_ff[k];
            if (x >= r + bt) begin
               rx_ff[k+1] <= x - (r + bt);
               rr_ff[k+1] <= (r >> 1) + bt;
            end else begin
               rx_ff[k+1] <= x;
               rr_ff[k+1] <= r >> 1;
            end
            ms_ff[k+1] <= ms_ff[k];
         end
         len_ff[0] <= LEN_WIDTH'(rr_ff[SL]);
         for (int i = 0; i < 3; i++) begin
            nm_ff[0][i] <= (NUM_WIDTH'(ms_ff[SL][i]) << NORMAL_WIDTH)
                         + NUM_WIDTH'(rr_ff[SL]);
            rm_ff[0][i] <= '0;
            qt_ff[0][i] <= '0;
         end
         for (int k = 0; k < DL; k++) begin
            len_ff[k+1] <= len_ff[k];
            d2 = (NUM_WIDTH+1)'(len_ff[k]) << 1;
            for (int i = 0; i < 3; i++) begin
               rem = {rm_ff[k][i][NUM_WIDTH-1:0], nm_ff[k][i][NUM_WIDTH-1-k]};
               nm_ff[k+1][i] <= nm_ff[k][i];
               if (rem >= d2 && d2 != 0) begin
                  rm_ff[k+1][i] <= rem - d2;
                  qt_ff[k+1][i] <= {qt_ff[k][i][NUM_WIDTH-2:0], 1'b1};
               end else begin
                  rm_ff[k+1][i] <= rem;
                  qt_ff[k+1][i] <= {qt_ff[k][i][NUM_WIDTH-2:0], 1'b0};
               end
            end
         end
         for (int i = 0; i < 3; i++) begin
            if (dg_ff[TOT-1]) begin
               o_ff[i] <= (i == 1) ? QMAX : '0;
            end else if (qt_ff[DL][i] > NUM_WIDTH'(QMAX)) begin
               o_ff[i] <= neg_ff[TOT-1][i] ? -QMAX : QMAX;
            end else begin
               o_ff[i] <= neg_ff[TOT-1][i] ? -NORMAL_WIDTH'(qt_ff[DL][i])
                                          : NORMAL_WIDTH'(qt_ff[DL][i]);
            end
         end
      end
   end

   assign out_valid      = vld_ff[TOT];
   assign n              = o_ff;
   assign out_degenerate = dg_ff[TOT];

endmodule

>>> rtl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: cross product, scaling, sqrt and divide.
//
//   channel   dir   contents
//   req_      in    nine Q12.12 vertex coordinates
//   rsp_      out   three Q1.15 normal components, degenerate flag
//   csr_      in    min_length, Q8.24
//
// One triangle per cycle while the pipeline is not frozen; the stages are 3 cross stages,
// 3 scale stages, the pipelined square root (31 steps) and the restoring
// dividers (47 steps), an input, a load and a result register, and the output register.
// The pipeline freezes as a whole when rsp_tready is low and
// the output register holds a word. Reset clears the valid bits and sets
// min_length to 1678.
// ----------------------------------------------------------------------------
module triangle_face_normal (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z
   input  logic [8*tfn_pkg::REQ_BYTES-1:0] req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [8*tfn_pkg::RSP_BYTES-1:0] rsp_tdata,
   // degenerate
   output logic          rsp_tuser,
   input  logic          csr_wen,
   input  logic [31:0]   csr_wdata
);
   import tfn_pkg::*;

   logic        enable;
   logic [31:0] min_length_ff;
   coord_type   p [9];
   logic        cv, sv, nv, sdg, ndg;
   cross_type   c [3];
   mant_type    m [3];
   logic [2:0]  sneg;
   logic [NORMAL_WIDTH-1:0] n [3];
   logic        ov_ff;
   logic [8*RSP_BYTES-1:0] od_ff;
   logic        ou_ff;

   assign enable     = !ov_ff || rsp_tready;
   assign req_tready = enable;

   always_comb begin
      for (int i = 0; i < 9; i++) p[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
      end else if (csr_wen) begin
         min_length_ff <= csr_wdata;
      end
   end

   tfn_cross u_cross (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req_tvalid), .p(p), .out_valid(cv), .c(c)
   );

   tfn_scale u_scale (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(cv), .c(c),
      .min_length(min_length_ff), .out_valid(sv), .m(m), .neg(sneg),
      .degenerate(sdg)
   );

   tfn_norm u_norm (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(sv), .m(m),
      .neg(sneg), .degenerate(sdg), .out_valid(nv), .n(n),
      .out_degenerate(ndg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (enable) begin
         ov_ff <= nv;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         od_ff <= (8*RSP_BYTES)'({n[2], n[1], n[0]});
         ou_ff <= ndg;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;

endmodule

>>> tb/triangle_face_normal_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_test
// Streams triangles through the face normal block, predicts each unit normal
// and degenerate flag in the scoreboard and checks every result word in
// order, across several min_length settings and flow control patterns.
// ----------------------------------------------------------------------------
module triangle_face_normal_test;
   import tfn_pkg::*;

   localparam int REQ_W = 8 * REQ_BYTES;
   localparam int RSP_W = 8 * RSP_BYTES;

   typedef logic [REQ_W-1:0] tri_word_t;

   typedef struct packed {
      logic [NORMAL_WIDTH-1:0] nx;
      logic [NORMAL_WIDTH-1:0] ny;
      logic [NORMAL_WIDTH-1:0] nz;
      logic                    degenerate;
   } normal_t;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= r + bit_v) begin
            x = x - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic normal_t face_normal(input tri_word_t d, input logic [31:0] min_len);
      longint p[9];
      longint e1[3], e2[3], c[3];
      logic [63:0] a[3], m[3];
      bit neg[3];
      bit above;
      int b, s, n;
      logic [65:0] sum, thr;
      logic [63:0] len, q;
      normal_t r;
      for (int i = 0; i < 9; i++) p[i] = longint'($signed(d[i*COORD_WIDTH +: COORD_WIDTH]));
      for (int i = 0; i < 3; i++) begin
         e1[i] = p[3+i] - p[i];
         e2[i] = p[6+i] - p[i];
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      above = 0;
      b = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i] < 0;
         a[i] = neg[i] ? 64'(-c[i]) : 64'(c[i]);
         if (a[i] > 64'hFFFF_FFFF) above = 1;
         n = 0;
         for (int k = 0; k < 64; k++) if (a[i][k]) n = k + 1;
         if (n > b) b = n;
      end
      if (!above) begin
         sum = 0;
         for (int i = 0; i < 3; i++) sum = sum + 66'(a[i] * a[i]);
         thr = 66'(min_len) * 66'(min_len);
         above = sum > thr;
      end
      if (!above) begin
         r.nx = 0;
         r.ny = QMAX;
         r.nz = 0;
         r.degenerate = 1;
         return r;
      end
      s = b - 30;
      for (int i = 0; i < 3; i++) begin
         m[i] = (s > 0) ? (a[i] >> s) : (a[i] << (-s));
         m[i] = m[i] & 64'h3FFF_FFFF;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = (len == 0) ? 64'd0 : ((m[i] << NORMAL_WIDTH) + len) / (2 * len);
         if (q > QMAX) q = QMAX;
         if (neg[i]) q = -q;
         if (i == 0) r.nx = q[NORMAL_WIDTH-1:0];
         else if (i == 1) r.ny = q[NORMAL_WIDTH-1:0];
         else r.nz = q[NORMAL_WIDTH-1:0];
      end
      r.degenerate = 0;
      return r;
   endfunction

   class normal_board;
      normal_t expected_normals[$];
      int errors = 0;

      function void note(tri_word_t d, logic [31:0] min_len);
         expected_normals.push_back(face_normal(d, min_len));
      endfunction

      function void check(normal_t got);
         normal_t want;
         if (expected_normals.size() == 0) begin
            $display("%0t unexpected word: got %h", $time, got);
            errors++;
            return;
         end
         want = expected_normals.pop_front();
         if (want.nx !== got.nx) begin
            $display("%0t normal_x: expected %h, got %h", $time, want.nx, got.nx);
            errors++;
         end
         if (want.ny !== got.ny) begin
            $display("%0t normal_y: expected %h, got %h", $time, want.ny, got.ny);
            errors++;
         end
         if (want.nz !== got.nz) begin
            $display("%0t normal_z: expected %h, got %h", $time, want.nz, got.nz);
            errors++;
         end
         if (want.degenerate !== got.degenerate) begin
            $display("%0t degenerate: expected %b, got %b", $time, want.degenerate,
                     got.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_tvalid = 0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tuser;
   logic               csr_wen = 0;
   logic [31:0]        csr_wdata = '0;

   normal_board board = new();
   logic [31:0] min_now = MIN_LENGTH_RESET;
   int send_gap_pct = 35;
   int recv_stall_pct = 78;
   int hold_left = 0;

   triangle_face_normal i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 0;
         end else if (hold_left > 0) begin
            rsp_tready = 0;
            hold_left--;
         end else begin
            rsp_tready = $urandom_range(99) >= recv_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      normal_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.nx = rsp_tdata[0 +: NORMAL_WIDTH];
         got.ny = rsp_tdata[NORMAL_WIDTH +: NORMAL_WIDTH];
         got.nz = rsp_tdata[2*NORMAL_WIDTH +: NORMAL_WIDTH];
         got.degenerate = rsp_tuser;
         board.check(got);
      end
   end

   function automatic tri_word_t make_tri(input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
      tri_word_t d;
      d = '0;
      d[0*COORD_WIDTH +: COORD_WIDTH] = x0[COORD_WIDTH-1:0];
      d[1*COORD_WIDTH +: COORD_WIDTH] = y0[COORD_WIDTH-1:0];
      d[2*COORD_WIDTH +: COORD_WIDTH] = z0[COORD_WIDTH-1:0];
      d[3*COORD_WIDTH +: COORD_WIDTH] = x1[COORD_WIDTH-1:0];
      d[4*COORD_WIDTH +: COORD_WIDTH] = y1[COORD_WIDTH-1:0];
      d[5*COORD_WIDTH +: COORD_WIDTH] = z1[COORD_WIDTH-1:0];
      d[6*COORD_WIDTH +: COORD_WIDTH] = x2[COORD_WIDTH-1:0];
      d[7*COORD_WIDTH +: COORD_WIDTH] = y2[COORD_WIDTH-1:0];
      d[8*COORD_WIDTH +: COORD_WIDTH] = z2[COORD_WIDTH-1:0];
      return d;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(4))
         0: return -8388608;
         1: return 8388607;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic tri_word_t random_tri();
      tri_word_t d;
      int v[9];
      int spread, k;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            for (int i = 0; i < 9; i++) v[i] = $urandom;
         end
         6, 7: begin
            // small triangle around a random point, near the threshold
            spread = 1 << $urandom_range(12);
            for (int i = 0; i < 3; i++) v[i] = $urandom;
            for (int i = 3; i < 9; i++)
               v[i] = v[i-3*(i/3)] + $signed($urandom_range(2 * spread)) - spread;
         end
         8: begin
            // collinear points
            k = $signed($urandom_range(8)) - 4;
            for (int i = 0; i < 3; i++) begin
               v[i] = $urandom;
               v[3+i] = v[i] + $signed($urandom_range(4000)) - 2000;
               v[6+i] = v[i] + k * (v[3+i] - v[i]);
            end
         end
         default: begin
            for (int i = 0; i < 9; i++) v[i] = pick_extreme();
         end
      endcase
      d = make_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
      return d;
   endfunction

   task automatic send_tri(input tri_word_t d);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tdata = d;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      board.note(d, min_now);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (board.expected_normals.size() != 0) @(negedge clock);
   endtask

   task automatic write_min_length(input logic [31:0] v);
      drain();
      repeat (120) @(negedge clock);
      csr_wdata = v;
      csr_wen = 1;
      @(negedge clock);
      csr_wen = 0;
      min_now = v;
   endtask

   initial begin
      logic [31:0] settings[6];
      settings[0] = 32'd0;
      settings[1] = 32'hFFFF_FFFF;
      settings[2] = 32'd1;
      settings[3] = 32'd1 << 20;
      settings[4] = $urandom;
      settings[5] = MIN_LENGTH_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, axis normals, degenerate and threshold edges
      send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_tri(make_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                        8388607, 8388607, 8388607));
      send_tri(make_tri(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                        -8388608, 8388607, -8388608));
      send_tri(make_tri(8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
                        8388607, -8388608, 8388607));
      send_tri(make_tri(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                        -8388608, -8388608, 8388607));
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
      send_tri(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
      send_tri(make_tri(0, 0, 0, 0, 4096, 0, 0, 0, 4096));
      send_tri(make_tri(0, 0, 0, 0, 0, 4096, 0, 4096, 0));
      send_tri(make_tri(0, 0, 0, 0, 0, 4096, 4096, 0, 0));
      send_tri(make_tri(0, 0, 0, 4096, 0, 0, 0, 0, 4096));
      send_tri(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
      send_tri(make_tri(5, 5, 5, 5, 5, 5, 7, 1, -3));
      send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_tri(make_tri(0, 0, 0, 1678, 0, 0, 0, 1, 0));
      send_tri(make_tri(0, 0, 0, 1679, 0, 0, 0, 1, 0));
      send_tri(make_tri(-100, 200, -300, -100, 200, 1378, -100, 201, -300));
      send_tri(make_tri(1000, -1000, 0, 3000, 500, 700, -2000, 800, -900));
      send_tri(make_tri(-8388608, 0, 8388607, 8388607, -8388608, 0, 0, 8388607, -8388608));
      send_tri(make_tri(0, 0, 0, 65536, 65536, 0, 0, 65536, 65536));

      for (int ph = 0; ph < 6; ph++) begin
         write_min_length(settings[ph]);
         if (ph < 2) begin
            send_gap_pct = 35;
            recv_stall_pct = 78;
         end else if (ph < 4) begin
            send_gap_pct = 78;
            recv_stall_pct = 35;
         end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         if (ph == 4) hold_left = 400;
         for (int i = 0; i < 115; i++) begin
            if (ph == 3 && i == 55) drain();
            send_tri(random_tri());
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_scale.sv
rtl/tfn_norm.sv
rtl/triangle_face_normal.sv
tb/triangle_face_normal_test.sv
